// File: rtl/bfld_pkg.sv
// Shared types, sizes and codes for the byte FIFO with line delimiter detect.
// No dependencies; the top level, bfld_cell and bfld_ctrl import this package.
package bfld_pkg;

    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int THR_W     = 7;
    localparam int FILL_W    = 7;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CMP_W     = (THR_W > CNT_W) ? THR_W : CNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_EN  = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT   = 2'd0,
        FN_READ  = 2'd1,
        FN_LINE  = 2'd2,
        FN_FLUSH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_RECOUNT
    } state_t;

    // Broadcast to every cell of the byte chain.
    typedef struct packed {
        logic              shift;   // every cell takes its neighbor's byte
        logic              rotate;  // tail cell takes the head byte instead
        logic              put;     // tail cell takes data
        logic [IDX_W-1:0]  tail;
        logic [BYTE_W-1:0] data;
    } cell_ctrl_t;

    typedef struct packed {
        logic              has_byte;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              accepted;
        logic [FILL_W-1:0] fill_count;
        logic              readable;
    } result_t;

    function automatic logic readable_f(input logic [CNT_W-1:0] cnt,
                                        input logic [CNT_W-1:0] dcnt,
                                        input logic             en,
                                        input logic [THR_W-1:0] thr);
        logic r;
        if (cnt == '0) begin
            r = 1'b0;
        end else if (en) begin
            r = (dcnt != '0);
        end else if (thr != '0) begin
            r = (CMP_W'(cnt) >= CMP_W'(thr));
        end else begin
            r = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/byte_fifo_line_delimiter.sv
// Top level of the byte FIFO with line delimiter detect.
// Depends on bfld_pkg, bfld_cell (byte chain) and bfld_ctrl (sequencer).
//
// Usage:
//   Requests enter on the s_ channel: s_tuser picks put, read, line read or
//   flush; s_tdata carries the byte to put and the read length limit.
//   Results leave on the m_ channel, one per popped byte, or one for a
//   request that pops nothing; m_tlast marks the final result of a request.
//   Every result reports the fill count and the readable flag after it.
//   The cfg_ channel writes threshold, delimiter and delimiter enable; write
//   it only while no request is in flight.
// Timing:
//   A put, flush or empty read gives its result in the cycle after acceptance,
//   and the next request can be taken in that same cycle while the receiver
//   is ready: one per cycle. A read pops one byte per cycle from the head
//   cell of the chain while the receiver is ready; the next request is taken after the final byte.
//   A delimiter write to a non-empty FIFO rotates the chain once to recount
//   the stored delimiters, with s_tready and cfg_ready held low meanwhile.
// Reset (aresetn low, synchronous) empties the FIFO, zeroes all config
// registers and drops any pending result. When the receiver stalls, the
// output register holds its result and s_tready stays low.
module byte_fifo_line_delimiter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [14:8] max_len, [15] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [8] accepted, [15:9] fill_count,
                                   // [16] readable, [23:17] zero
    output logic        m_tuser,   // [0] has_byte
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import bfld_pkg::*;

    cell_ctrl_t        cell_ctrl;
    result_t           res;
    logic [BYTE_W-1:0] cell_bytes [DEPTH];

    // Sequencer: decode requests, keep counts, drive the chain.
    bfld_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (func_t'(s_tuser)),
        .in_data    (s_tdata[7:0]),
        .in_max_len (s_tdata[14:8]),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_byte  (cell_bytes[0]),
        .cell_ctrl  (cell_ctrl),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    // Byte chain: cell 0 is the head (oldest byte); each cell takes its
    // upper neighbor's byte on a pop; the top cell takes zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [BYTE_W-1:0] nb;
        if (g < DEPTH - 1) begin : g_mid
            assign nb = cell_bytes[g + 1];
        end else begin : g_top
            assign nb = '0;
        end
        bfld_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .cell_idx  (IDX_W'(g)),
            .next_byte (nb),
            .head_byte (cell_bytes[0]),
            .cell_byte (cell_bytes[g])
        );
    end

    // Pack the result fields onto the master side.
    assign m_tdata = {7'b0, res.readable, res.fill_count, res.accepted, res.out_byte};
    assign m_tuser = res.has_byte;
    assign m_tlast = res.last;

endmodule

// File: rtl/bfld_cell.sv
// One byte cell of the FIFO chain: holds a byte, shifts toward the head.
// Depends on bfld_pkg.
module bfld_cell (
    input  logic                                aclk,
    input  bfld_pkg::cell_ctrl_t                ctrl,
    input  logic [bfld_pkg::IDX_W-1:0]          cell_idx,
    input  logic [bfld_pkg::BYTE_W-1:0]         next_byte,
    input  logic [bfld_pkg::BYTE_W-1:0]         head_byte,
    output logic [bfld_pkg::BYTE_W-1:0]         cell_byte
);
    import bfld_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              at_tail;

    assign at_tail = (cell_idx == ctrl.tail);

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.put && at_tail) begin
            byte_next = ctrl.data;
        end else if (ctrl.shift) begin
            // wrap the head byte around to the tail during a recount
            byte_next = (ctrl.rotate && at_tail) ? head_byte : next_byte;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

// File: rtl/bfld_ctrl.sv
// Sequencer of the FIFO: counts, config registers, pop loop, recount, output register.
// Depends on bfld_pkg; drives the cell chain through cell_ctrl_t.
module bfld_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bfld_pkg::func_t                in_func,
    input  logic [bfld_pkg::BYTE_W-1:0]    in_data,
    input  logic [bfld_pkg::LEN_W-1:0]     in_max_len,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bfld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfld_pkg::BYTE_W-1:0]    cfg_data,
    input  logic [bfld_pkg::BYTE_W-1:0]    head_byte,
    output bfld_pkg::cell_ctrl_t           cell_ctrl,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bfld_pkg::result_t              out_res
);
    import bfld_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic               line_reg, line_next;
    logic [CNT_W-1:0]   rc_idx_reg, rc_idx_next;
    logic [CNT_W-1:0]   rc_acc_reg, rc_acc_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [BYTE_W-1:0]  delim_reg, delim_next;
    logic               den_reg, den_next;
    logic               m_valid_reg, m_valid_next;
    result_t            res_reg, res_next;

    logic               slot_free;
    logic               emit;
    logic               pop_go;
    logic [LEN_W-1:0]   pop_rem;
    logic               pop_line;
    logic               pop_last;
    logic               head_match;
    logic               line_mode;
    logic               cfg_take;
    logic [CNT_W-1:0]   count_m1;

    assign slot_free  = !m_valid_reg || out_ready;
    assign head_match = (head_byte == delim_reg);
    assign count_m1   = count_reg - CNT_W'(1);
    assign cfg_ready  = (state_reg != ST_RECOUNT);
    assign cfg_take   = cfg_valid && cfg_ready;
    assign in_ready   = (state_reg == ST_IDLE) && slot_free;
    assign line_mode  = (in_func == FN_LINE) && den_reg;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        dcnt_next   = dcnt_reg;
        rem_next    = rem_reg;
        line_next   = line_reg;
        rc_idx_next = rc_idx_reg;
        rc_acc_next = rc_acc_reg;
        cell_ctrl   = '0;
        cell_ctrl.tail = count_reg[IDX_W-1:0];
        cell_ctrl.data = in_data;
        res_next    = '0;
        emit        = 1'b0;
        pop_go      = 1'b0;
        pop_rem     = in_max_len;
        pop_line    = line_mode;
        pop_last    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && in_ready) begin
                    unique case (in_func)
                        FN_PUT: begin
                            emit          = 1'b1;
                            res_next.last = 1'b1;
                            if (count_reg < CNT_W'(DEPTH)) begin
                                cell_ctrl.put     = 1'b1;
                                count_next        = count_reg + CNT_W'(1);
                                dcnt_next         = dcnt_reg + CNT_W'(in_data == delim_reg);
                                res_next.accepted = 1'b1;
                            end
                        end
                        FN_FLUSH: begin
                            emit          = 1'b1;
                            res_next.last = 1'b1;
                            count_next    = '0;
                            dcnt_next     = '0;
                        end
                        FN_READ, FN_LINE: begin
                            if (count_reg == '0 || in_max_len == '0 ||
                                (line_mode && dcnt_reg == '0)) begin
                                emit          = 1'b1;
                                res_next.last = 1'b1;
                            end else begin
                                pop_go = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP: begin
                pop_rem  = rem_reg;
                pop_line = line_reg;
                pop_go   = slot_free;
            end
            ST_RECOUNT: begin
                // rotate the chain once around, counting matches at the head
                cell_ctrl.shift  = 1'b1;
                cell_ctrl.rotate = 1'b1;
                cell_ctrl.tail   = count_m1[IDX_W-1:0];
                if (rc_idx_reg == count_m1) begin
                    dcnt_next  = rc_acc_reg + CNT_W'(head_match);
                    state_next = ST_IDLE;
                end else begin
                    rc_idx_next = rc_idx_reg + CNT_W'(1);
                    rc_acc_next = rc_acc_reg + CNT_W'(head_match);
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (pop_go) begin
            pop_last = (pop_rem == LEN_W'(1)) || (count_reg == CNT_W'(1)) ||
                       (pop_line && head_match);
            cell_ctrl.shift   = 1'b1;
            count_next        = count_m1;
            dcnt_next         = dcnt_reg - CNT_W'(head_match);
            emit              = 1'b1;
            res_next.has_byte = 1'b1;
            res_next.out_byte = head_byte;
            res_next.last     = pop_last;
            if (pop_last) begin
                state_next = ST_IDLE;
            end else begin
                state_next = ST_POP;
                rem_next   = pop_rem - LEN_W'(1);
                line_next  = pop_line;
            end
        end

        res_next.fill_count = FILL_W'(count_next);
        res_next.readable   = readable_f(count_next, dcnt_next, den_reg, thr_reg);

        // a new delimiter invalidates the kept match count
        if (cfg_take && cfg_index == CFG_DELIMITER && count_reg != '0) begin
            state_next  = ST_RECOUNT;
            rc_idx_next = '0;
            rc_acc_next = '0;
        end

        m_valid_next = slot_free ? emit : m_valid_reg;
    end

    always_comb begin
        thr_next   = thr_reg;
        delim_next = delim_reg;
        den_next   = den_reg;
        if (cfg_take) begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_next   = cfg_data[THR_W-1:0];
                CFG_DELIMITER: delim_next = cfg_data;
                CFG_DELIM_EN:  den_next   = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dcnt_reg    <= '0;
            rem_reg     <= '0;
            line_reg    <= 1'b0;
            rc_idx_reg  <= '0;
            rc_acc_reg  <= '0;
            thr_reg     <= '0;
            delim_reg   <= '0;
            den_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dcnt_reg    <= dcnt_next;
            rem_reg     <= rem_next;
            line_reg    <= line_next;
            rc_idx_reg  <= rc_idx_next;
            rc_acc_reg  <= rc_acc_next;
            thr_reg     <= thr_next;
            delim_reg   <= delim_next;
            den_reg     <= den_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && emit) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_res   = res_reg;

endmodule

// File: rtl/bfld_checker.sv
// Port-level checks of the byte FIFO with line delimiter detect, and its bind.
// Depends on byte_fifo_line_delimiter; sees its ports only.
module bfld_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Take no request while a finished result is stuck.
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken with output stalled");

    // A result without a byte carries a zero byte.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("empty result carries a byte");

    // A stored put ends its request and pops nothing.
    a_put_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tlast && !m_tuser)
        else $error("accepted flag on a pop result");

    // Readable needs at least one stored byte.
    a_readable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> m_tdata[15:9] != 7'd0)
        else $error("readable with empty FIFO");

endmodule

bind byte_fifo_line_delimiter bfld_checker u_bfld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
